[rtl/tmse_pkg.sv]
`timescale 1ns / 1ps

package tmse_pkg;

    // Field widths of one request and one response.
    localparam int unsigned REQ_TYPE_W   = 2;
    localparam int unsigned OPCODE_W     = 4;
    localparam int unsigned TARGET_W     = 12;
    localparam int unsigned IN_VALUE_W   = 16;
    localparam int unsigned JUMP_INDEX_W = 13;
    localparam int unsigned PROG_LEN_W   = 13;
    localparam int unsigned STATUS_W     = 3;
    localparam int unsigned PC_FIELD_W   = 12;
    localparam int unsigned PTR_FIELD_W  = 12;
    localparam int unsigned CELL_FIELD_W = 16;
    localparam int unsigned CHAR_W       = 8;

    // Request types.
    localparam logic [REQ_TYPE_W-1:0] REQ_EXEC  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_JUMP  = 2'd2;

    // Instruction opcodes.
    localparam logic [OPCODE_W-1:0] OP_END      = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_PTR_INC  = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_PTR_DEC  = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_CELL_INC = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_CELL_DEC = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_OUT      = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_IN       = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_JZ       = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_JNZ      = 4'd8;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd4;

    // Operation of the shared increment/decrement unit.
    typedef enum logic {
        INCDEC_INC,
        INCDEC_DEC
    } t_incdec_op;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]   req_type;
        logic [OPCODE_W-1:0]     opcode;
        logic [TARGET_W-1:0]     target;
        logic [IN_VALUE_W-1:0]   in_value;
        logic [JUMP_INDEX_W-1:0] jump_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [PC_FIELD_W-1:0]   next_pc;
        logic [PTR_FIELD_W-1:0]  data_pointer;
        logic [CELL_FIELD_W-1:0] cell_value;
        logic                    out_valid;
        logic [CHAR_W-1:0]       out_char;
        logic                    is_running;
    } t_rsp;

endpackage

[rtl/tmse_incdec.sv]
`timescale 1ns / 1ps

module tmse_incdec #(
    parameter int unsigned W = 17
) (
    input  tmse_pkg::t_incdec_op i_op,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_limit,
    output logic [W-1:0]         o_res,
    output logic                 o_at_limit
);
    import tmse_pkg::*;

    // One adder serves every pointer, cell, counter and sweep update.
    always_comb begin
        unique case (i_op)
            INCDEC_INC: o_res = i_a + W'(1);
            INCDEC_DEC: o_res = i_a - W'(1);
            default:    o_res = i_a;
        endcase
    end

    // The bound check follows the adder, for wrap and overflow decisions.
    assign o_at_limit = (o_res >= i_limit);

endmodule

[rtl/tmse_tape_ram.sv]
`timescale 1ns / 1ps

module tmse_tape_ram #(
    parameter  int unsigned DEPTH = 4096,
    parameter  int unsigned DW    = 16,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tape_machine_step_executor_unit.sv]
`timescale 1ns / 1ps
// Sequence: an accepted execute or jump request passes the execute state and the result state;
// in-range pointer moves and cell add/subtract also pass a fetch or PC-advance state (tape RAM
// read, or a second pass through the shared incrementer). A start request runs the tape clear sweep.
// A new request is taken only in idle, once the response to the last one has been loaded.
// Reset: synchronous, active low; afterwards a clear pass over every tape cell runs with
// requests stalled, and the program length register returns to 1.

module tape_machine_step_executor_unit #(
    parameter int unsigned TAPE_CELLS    = 4096,
    parameter int unsigned PROGRAM_DEPTH = 4096,
    parameter int unsigned CELL_BITS     = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    output logic                                 o_req_stall,
    input  tmse_pkg::t_req                       i_req,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_stall,
    output tmse_pkg::t_rsp                       o_rsp,
    input  logic                                 i_cfg_we,
    input  logic [tmse_pkg::PROG_LEN_W-1:0]      i_cfg_wdata
);
    import tmse_pkg::*;

    localparam int unsigned AW  = $clog2(TAPE_CELLS);
    localparam int unsigned PCW = $clog2(PROGRAM_DEPTH);
    localparam int unsigned W0  = (CELL_BITS > AW + 1) ? CELL_BITS : AW + 1;
    localparam int unsigned W1  = (W0 > PCW + 1) ? W0 : PCW + 1;
    localparam int unsigned W   = (W1 > JUMP_INDEX_W) ? W1 : JUMP_INDEX_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_PCADV,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_clr_report;
    logic [PCW-1:0]          r_pc;
    logic [AW-1:0]           r_ptr;
    logic                    r_run;
    logic [CELL_BITS-1:0]    r_cur_cell;
    logic [PROG_LEN_W-1:0]   r_prog_len;
    t_req                    r_req;
    logic [STATUS_W-1:0]     r_status;
    logic                    r_ovalid;
    logic [CHAR_W-1:0]       r_ochar;
    logic                    r_rsp_valid;
    t_rsp                    r_rsp;

    t_incdec_op              w_op;
    logic [W-1:0]            w_a;
    logic [W-1:0]            w_limit;
    logic [W-1:0]            w_res;
    logic                    w_at_limit;
    logic                    w_exec_go;
    logic                    w_take;
    logic [W-1:0]            w_jidx;
    logic [W-1:0]            w_plen;
    logic [W-1:0]            w_jlimit;
    logic                    w_jump_bad;
    logic                    w_mem_we;
    logic [AW-1:0]           w_mem_waddr;
    logic [CELL_BITS-1:0]    w_mem_wdata;
    logic                    w_mem_re;
    logic [CELL_BITS-1:0]    w_mem_rdata;
    logic [PCW-1:0]          w_pc_adv;
    t_rsp                    w_rsp;

    // An execute request on a running machine does the real work.
    assign w_exec_go = (r_state == S_EXEC) && (r_req.req_type == REQ_EXEC) && r_run;

    // Bracket condition on the current cell.
    assign w_take = ((r_req.opcode == OP_JZ) && (r_cur_cell == '0))
                 || ((r_req.opcode == OP_JNZ) && (r_cur_cell != '0));

    // Jump bound: the lesser of the program length and the program depth.
    assign w_jidx     = W'(r_req.jump_index);
    assign w_plen     = W'(r_prog_len);
    assign w_jlimit   = (w_plen < W'(PROGRAM_DEPTH)) ? w_plen : W'(PROGRAM_DEPTH);
    assign w_jump_bad = !r_run || (w_jidx == '0) || (w_jidx > w_jlimit);

    // Operand selection for the shared incrementer.
    always_comb begin
        w_op    = INCDEC_INC;
        w_a     = '0;
        w_limit = W'(PROGRAM_DEPTH);
        unique case (r_state)
            S_CLEAR: begin
                w_a     = W'(r_clr_addr);
                w_limit = W'(TAPE_CELLS);
            end
            S_EXEC: begin
                if (r_req.req_type == REQ_JUMP) begin
                    w_op = INCDEC_DEC;
                    w_a  = w_jidx;
                end else begin
                    unique case (r_req.opcode)
                        OP_PTR_INC: begin
                            w_a     = W'(r_ptr);
                            w_limit = W'(TAPE_CELLS);
                        end
                        OP_PTR_DEC: begin
                            w_op = INCDEC_DEC;
                            w_a  = W'(r_ptr);
                        end
                        OP_CELL_INC: begin
                            w_a = W'(r_cur_cell);
                        end
                        OP_CELL_DEC: begin
                            w_op = INCDEC_DEC;
                            w_a  = W'(r_cur_cell);
                        end
                        default: begin
                            w_a = w_take ? W'(r_req.target) : W'(r_pc);
                        end
                    endcase
                end
            end
            S_FETCH, S_PCADV: begin
                w_a = W'(r_pc);
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    tmse_incdec #(
        .W (W)
    ) u_incdec (
        .i_op       (w_op),
        .i_a        (w_a),
        .i_limit    (w_limit),
        .o_res      (w_res),
        .o_at_limit (w_at_limit)
    );

    // The program counter wraps to zero at the program depth.
    assign w_pc_adv = w_at_limit ? '0 : PCW'(w_res);

    // Tape port control: clear sweep, cell writes, and reads after a pointer move.
    assign w_mem_we = (r_state == S_CLEAR)
                   || (w_exec_go && ((r_req.opcode == OP_CELL_INC)
                                  || (r_req.opcode == OP_CELL_DEC)
                                  || (r_req.opcode == OP_IN)));
    assign w_mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_ptr;
    assign w_mem_wdata = (r_state == S_CLEAR)    ? '0 :
                         (r_req.opcode == OP_IN) ? CELL_BITS'(r_req.in_value) :
                                                   CELL_BITS'(w_res);
    assign w_mem_re = w_exec_go && (((r_req.opcode == OP_PTR_INC) && !w_at_limit)
                                 || ((r_req.opcode == OP_PTR_DEC) && (r_ptr != '0)));

    tmse_tape_ram #(
        .DEPTH (TAPE_CELLS),
        .DW    (CELL_BITS)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (AW'(w_res)),
        .o_rdata (w_mem_rdata)
    );

    // Response assembled from the machine state.
    always_comb begin
        w_rsp.status       = r_status;
        w_rsp.next_pc      = PC_FIELD_W'(r_pc);
        w_rsp.data_pointer = PTR_FIELD_W'(r_ptr);
        w_rsp.cell_value   = CELL_FIELD_W'(r_cur_cell);
        w_rsp.out_valid    = r_ovalid;
        w_rsp.out_char     = r_ochar;
        w_rsp.is_running   = r_run;
    end

    // Sequencer, machine state and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_pc         <= '0;
            r_ptr        <= '0;
            r_run        <= 1'b0;
            r_cur_cell   <= '0;
            r_prog_len   <= PROG_LEN_W'(1);
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prog_len <= i_cfg_wdata;
            end
            // The result state reloads the response itself when it is taken.
            if (r_rsp_valid && !i_rsp_stall && (r_state != S_OUT)) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (w_at_limit) begin
                        r_clr_addr <= '0;
                        r_state    <= r_clr_report ? S_OUT : S_IDLE;
                    end else begin
                        r_clr_addr <= AW'(w_res);
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req    <= i_req;
                        r_status <= ST_OK;
                        r_ovalid <= 1'b0;
                        r_ochar  <= '0;
                        if (i_req.req_type == REQ_START) begin
                            r_pc         <= '0;
                            r_ptr        <= '0;
                            r_run        <= 1'b1;
                            r_cur_cell   <= '0;
                            r_clr_addr   <= '0;
                            r_clr_report <= 1'b1;
                            r_state      <= S_CLEAR;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    priority if (r_req.req_type == REQ_JUMP) begin
                        r_state <= S_OUT;
                        if (w_jump_bad) begin
                            r_status <= ST_REJECT;
                        end else begin
                            r_pc <= PCW'(w_res);
                        end
                    end else if ((r_req.req_type == REQ_EXEC) && r_run) begin
                        unique case (r_req.opcode)
                            OP_END: begin
                                r_run    <= 1'b0;
                                r_status <= ST_END;
                                r_state  <= S_OUT;
                            end
                            OP_PTR_INC: begin
                                if (w_at_limit) begin
                                    r_run    <= 1'b0;
                                    r_status <= ST_OVER;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_ptr   <= AW'(w_res);
                                    r_state <= S_FETCH;
                                end
                            end
                            OP_PTR_DEC: begin
                                if (r_ptr == '0) begin
                                    r_run    <= 1'b0;
                                    r_status <= ST_UNDER;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_ptr   <= AW'(w_res);
                                    r_state <= S_FETCH;
                                end
                            end
                            OP_CELL_INC, OP_CELL_DEC: begin
                                r_cur_cell <= CELL_BITS'(w_res);
                                r_state    <= S_PCADV;
                            end
                            OP_OUT: begin
                                r_ovalid <= 1'b1;
                                r_ochar  <= CHAR_W'(r_cur_cell);
                                r_pc     <= w_pc_adv;
                                r_state  <= S_OUT;
                            end
                            OP_IN: begin
                                r_cur_cell <= CELL_BITS'(r_req.in_value);
                                r_pc       <= w_pc_adv;
                                r_state    <= S_OUT;
                            end
                            default: begin
                                r_pc    <= w_pc_adv;
                                r_state <= S_OUT;
                            end
                        endcase
                    end else begin
                        r_status <= ST_REJECT;
                        r_state  <= S_OUT;
                    end
                end
                S_FETCH: begin
                    r_cur_cell <= w_mem_rdata;
                    r_pc       <= w_pc_adv;
                    r_state    <= S_OUT;
                end
                S_PCADV: begin
                    r_pc    <= w_pc_adv;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_rsp_valid || !i_rsp_stall) begin
                        r_rsp_valid  <= 1'b1;
                        r_rsp        <= w_rsp;
                        r_clr_report <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // The tape port never reads and writes in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("tape read and write in the same cycle");

    // A start request enters the clear sweep with the machine running.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall && (i_req.req_type == REQ_START))
        |=> ((r_state == S_CLEAR) && r_run && (r_ptr == '0) && (r_pc == '0)))
        else $error("start request did not begin a clear sweep");

    // The sweep address rests at zero outside the sweep.
    a_clr_addr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_clr_addr == '0))
        else $error("clear address moved outside the sweep");

    // A response is loaded only from the result state.
    a_rsp_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> ($past(r_state) == S_OUT))
        else $error("response loaded outside the result state");

    // The running flag is raised only by a start request taken in idle.
    a_run_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_run) |-> (($past(r_state) == S_IDLE) && (r_state == S_CLEAR)))
        else $error("running flag set without a start request");

endmodule
